@@ src/positional_list_store_defines.svh @@
// assertion macros for the positional list store
// expects clk and rst in the scope of each use
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define PLS_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define PLS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pls_pkg.sv @@
// shared types and constants for the positional list store
// no dependencies
`default_nettype none

package pls_pkg;

  // most results a read-all request produces
  localparam int MAX_RESULTS = 16;

  // request operation codes
  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_APPEND    = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_UPDATE    = 3'd3,
    FN_DELETE    = 3'd4,
    FN_READ_ALL  = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic edit;      // apply an edit request and load its result
    logic rd_empty;  // load the empty-list result of a read-all
    logic rd_start;  // begin a read-all walk
    logic rd_step;   // advance the read-all walk by one element
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;     // list holds no elements
    logic out_free;  // result register can take a new result this cycle
    logic rd_emit;   // current walk step produces a result
    logic rd_done;   // current walk step is the final one
  } stat_t;

endpackage

`default_nettype wire

@@ src/pls_if.sv @@
// request and result channel interfaces for the positional list store
// depends on nothing beyond the field widths of the list store
`default_nettype none

// request channel: operation, position and value
interface pls_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [4:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

// result channel: status, element, slot, count and last flag
interface pls_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic [3:0]         slot;
  logic [4:0]         count;
  logic               last;

  modport source (output valid, output status, output element, output slot, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input element, input slot, input count,
                  input last, output ready);
endinterface

`default_nettype wire

@@ src/pls_datapath.sv @@
// datapath of the positional list store: element cell chain, length,
// read-all walk index and result register; uses pls_pkg and the assertion macros
`default_nettype none
`include "positional_list_store_defines.svh"

module pls_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pls_pkg::cmd_t      cmd,
  output      pls_pkg::stat_t     stat,
  input  wire logic [2:0]         func,
  input  wire logic [4:0]         position,
  input  wire logic signed [31:0] value,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         out_status,
  output      logic signed [31:0] out_element,
  output      logic [3:0]         out_slot,
  output      logic [4:0]         out_count,
  output      logic               out_last
);
  import pls_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;

  logic signed [31:0] cells [CAPACITY];
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic [IDX_W-1:0]   idx;

  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   len_c;
  logic [CMP_W-1:0]   idx_c;
  logic [CMP_W-1:0]   rd_n;
  logic [CMP_W-1:0]   ins_pos;
  logic               full;
  logic               ins_ok;
  logic               upd_ok;
  logic               del_ok;
  status_t            ed_status;
  logic signed [31:0] removed;
  logic               rd_last;
  logic               load;

  // widened operands for the bound compares
  assign pos_c = CMP_W'(position);
  assign len_c = CMP_W'(len);
  assign idx_c = CMP_W'(idx);
  assign full  = len_c >= CMP_W'(CAPACITY);

  // edit decode and status
  always_comb begin
    ins_pos   = '0;
    ins_ok    = 1'b0;
    upd_ok    = 1'b0;
    del_ok    = 1'b0;
    ed_status = ST_OK;
    case (func)
      FN_INS_FRONT: begin
        ins_pos = '0;
        if (full) ed_status = ST_FULL;
        else      ins_ok    = 1'b1;
      end
      FN_APPEND: begin
        ins_pos = len_c;
        if (full) ed_status = ST_FULL;
        else      ins_ok    = 1'b1;
      end
      FN_INS_AT: begin
        ins_pos = pos_c;
        if (pos_c > len_c) ed_status = ST_BOUNDS;
        else if (full)     ed_status = ST_FULL;
        else               ins_ok    = 1'b1;
      end
      FN_UPDATE: begin
        if (pos_c < len_c) upd_ok    = 1'b1;
        else               ed_status = ST_BOUNDS;
      end
      FN_DELETE: begin
        if (len_c == '0)         ed_status = ST_EMPTY;
        else if (pos_c >= len_c) ed_status = ST_BOUNDS;
        else                     del_ok    = 1'b1;
      end
      default: ed_status = ST_OK;
    endcase
  end

  // value taken out by a delete
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(i) == pos_c) removed = cells[i];
    end
  end

  // length after the edit
  always_comb begin
    len_next = len;
    if (cmd.edit && ins_ok)      len_next = len + LEN_W'(1);
    else if (cmd.edit && del_ok) len_next = len - LEN_W'(1);
  end

  // cell chain: insert shifts toward the tail, delete toward the head,
  // a read-all walk rotates the live part through the head cell
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] prev_val;
    logic signed [31:0] next_val;

    if (g == 0) begin : g_head
      assign prev_val = value;
    end else begin : g_body
      assign prev_val = cells[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_val = cells[0];
    end else begin : g_mid
      assign next_val = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.edit && ins_ok) begin
        if (CMP_W'(g) == ins_pos)     cells[g] <= value;
        else if (CMP_W'(g) > ins_pos) cells[g] <= prev_val;
      end else if (cmd.edit && upd_ok) begin
        if (CMP_W'(g) == pos_c) cells[g] <= value;
      end else if (cmd.edit && del_ok) begin
        if (CMP_W'(g) >= pos_c) cells[g] <= next_val;
      end else if (cmd.rd_step) begin
        if (CMP_W'(g + 1) < len_c)       cells[g] <= next_val;
        else if (CMP_W'(g + 1) == len_c) cells[g] <= cells[0];
      end
    end
  end

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  // read-all walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.rd_start) begin
      idx <= '0;
    end else if (cmd.rd_step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // walk step decode
  assign rd_n         = (len_c < CMP_W'(MAX_RESULTS)) ? len_c : CMP_W'(MAX_RESULTS);
  assign rd_last      = (idx_c + CMP_W'(1)) == rd_n;
  assign stat.rd_emit = idx_c < CMP_W'(MAX_RESULTS);
  assign stat.rd_done = (idx_c + CMP_W'(1)) == len_c;
  assign stat.empty   = (len == '0);
  assign stat.out_free = !out_valid || out_ready;

  assign load = cmd.edit || cmd.rd_empty || (cmd.rd_step && stat.rd_emit);

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.edit) begin
      out_status  <= ed_status;
      out_element <= del_ok ? removed : '0;
      out_slot    <= '0;
      out_count   <= 5'(len_next);
      out_last    <= 1'b1;
    end else if (cmd.rd_empty) begin
      out_status  <= ST_EMPTY;
      out_element <= '0;
      out_slot    <= '0;
      out_count   <= '0;
      out_last    <= 1'b1;
    end else if (cmd.rd_step && stat.rd_emit) begin
      out_status  <= ST_OK;
      out_element <= cells[0];
      out_slot    <= 4'(idx);
      out_count   <= 5'(len);
      out_last    <= rd_last;
    end
  end

  // checks
  `PLS_CHECK(a_len_cap, len <= LEN_W'(CAPACITY), "list length exceeds capacity")
  `PLS_IMPLY(a_load_free, load, stat.out_free, "result loaded over a pending result")
  `PLS_NEXT(a_walk_len, cmd.rd_step, $stable(len), "length changed during read-all walk")
  `PLS_NEXT(a_del_len, cmd.edit && del_ok, len == $past(len) - LEN_W'(1),
            "delete did not shorten the list")

endmodule

`default_nettype wire

@@ src/pls_ctrl.sv @@
// controller of the positional list store: request acceptance and read-all walk
// uses pls_pkg command and status types
`default_nettype none

module pls_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire logic [2:0]     func,
  input  wire pls_pkg::stat_t stat,
  output      pls_pkg::cmd_t  cmd
);
  import pls_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   step;

  // request acceptance and walk pacing
  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;
  assign step     = !stat.rd_emit || stat.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && func == FN_READ_ALL && !stat.empty) state_next = S_READ;
      end
      S_READ: begin
        if (step && stat.rd_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_INS_FRONT, FN_APPEND, FN_INS_AT, FN_UPDATE, FN_DELETE: cmd.edit = 1'b1;
            FN_READ_ALL: begin
              cmd.rd_empty = stat.empty;
              cmd.rd_start = !stat.empty;
            end
            default: cmd = '0;
          endcase
        end
      end
      S_READ: cmd.rd_step = step;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/positional_list_store.sv @@
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// values edited by position. Insert front, append, insert at, update at and
// delete at each take one request and give one result in the cycle after it
// is accepted; the whole edit, including the shift of the element chain,
// is registered with that result, so edits run at one request per cycle
// while results are taken. A read-all rotates the element chain through its
// head cell once, giving one result per element for the first 16 elements
// (the rest pass silently), and then returns to its original order. New
// requests are held off during that walk and whenever a result waits in the
// output register. No clearing pass follows reset; list entries are only
// read after they have been written.
// top level; uses pls_pkg, pls_if, pls_ctrl and pls_datapath
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  pls_req_if.sink   req_ch,
  pls_rsp_if.source rsp_ch
);
  import pls_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign req_ch.ready = in_ready;

  // request sequencing
  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_ch.valid),
    .in_ready (in_ready),
    .func     (req_ch.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // list storage and result register
  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (req_ch.func),
    .position    (req_ch.position),
    .value       (req_ch.value),
    .out_valid   (rsp_ch.valid),
    .out_ready   (rsp_ch.ready),
    .out_status  (rsp_ch.status),
    .out_element (rsp_ch.element),
    .out_slot    (rsp_ch.slot),
    .out_count   (rsp_ch.count),
    .out_last    (rsp_ch.last)
  );

endmodule

`default_nettype wire
